[src/ppd_pkg.sv]
// Shared widths, constants, register codes and state type of the PID position drive.
package ppd_pkg;

  localparam int DATA_W    = 32;
  localparam int WIDE_W    = DATA_W + 1;
  localparam int DEN_W     = 16;
  localparam int DT_W      = 16;
  localparam int GAIN_W    = 16;
  localparam int DRIVE_W   = 14;
  localparam int CFG_IDX_W = 3;
  localparam int MUL_A_W   = DATA_W + 2;
  localparam int MUL_P_W   = MUL_A_W + GAIN_W;
  localparam int SUM_W     = MUL_P_W + 2;
  localparam int SCALED_W  = SUM_W + 3;

  localparam int DRIVE_LIMIT = 5000;
  localparam int REACH_LIMIT = 1;

  localparam logic [DEN_W-1:0]   GEAR_RESET = DEN_W'(34);
  localparam logic [DRIVE_W-1:0] DRIVE_HI   = DRIVE_W'(DRIVE_LIMIT);
  localparam logic [DRIVE_W-1:0] DRIVE_LO   = DRIVE_W'(-DRIVE_LIMIT);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TARGET,
    REG_START,
    REG_GEAR,
    REG_GAIN_P,
    REG_GAIN_I,
    REG_GAIN_D
  } cfg_reg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PREP,
    S_DIV_POS,
    S_ERR,
    S_DIFF,
    S_DDIV,
    S_WAIT_DER,
    S_PID,
    S_WAIT_PID,
    S_SCALE,
    S_DONE
  } state_t;

endpackage

[src/ppd_divider.sv]
// Restoring unsigned divider, one quotient bit per cycle.
module ppd_divider #(
  parameter int NUM_W = ppd_pkg::WIDE_W,
  parameter int DEN_W = ppd_pkg::DEN_W
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quot
);
  import ppd_pkg::*;

  localparam int CNT_W = $clog2(NUM_W);

  logic [NUM_W-1:0] num_sh;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den_r;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [DEN_W:0]   rem_sh;
  logic [DEN_W:0]   rem_sub;
  logic             ge;

  assign rem_sh  = {rem, num_sh[NUM_W-1]};
  assign rem_sub = rem_sh - {1'b0, den_r};
  assign ge      = rem_sh >= {1'b0, den_r};
  assign quot    = num_sh;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == CNT_W'(NUM_W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // quotient bits shift in behind the numerator bits as they are used
  always_ff @(posedge clk) begin
    if (start) begin
      num_sh <= num;
      rem    <= '0;
      den_r  <= den;
    end else if (busy) begin
      rem    <= ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      num_sh <= {num_sh[NUM_W-2:0], ge};
    end
  end

endmodule

[src/ppd_serial_mult.sv]
// Shift-add multiplier, one multiplier bit per cycle; signed multiplicand.
module ppd_serial_mult #(
  parameter int A_W = ppd_pkg::MUL_A_W,
  parameter int B_W = ppd_pkg::GAIN_W
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               b_signed,
  input  logic [A_W-1:0]     a,
  input  logic [B_W-1:0]     b,
  output logic               done,
  output logic [A_W+B_W-1:0] product
);
  import ppd_pkg::*;

  localparam int P_W   = A_W + B_W;
  localparam int CNT_W = $clog2(B_W);

  logic [P_W-1:0]   areg;
  logic [B_W-1:0]   breg;
  logic [P_W-1:0]   acc;
  logic [P_W-1:0]   acc_next;
  logic [P_W-1:0]   addend;
  logic [CNT_W-1:0] cnt;
  logic             bsg;
  logic             busy;
  logic             last;

  assign last    = cnt == CNT_W'(B_W - 1);
  assign addend  = breg[0] ? areg : '0;
  // top bit of a signed multiplier carries negative weight
  assign acc_next = (last && bsg) ? acc - addend : acc + addend;
  assign product = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (last) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      areg <= {{B_W{a[A_W-1]}}, a};
      breg <= b;
      acc  <= '0;
      bsg  <= b_signed;
    end else if (busy) begin
      acc  <= acc_next;
      areg <= areg << 1;
      breg <= breg >> 1;
    end
  end

endmodule

[src/pid_position_drive_top.sv]
// The next input word is taken the cycle after a result loads; time is set by the passes of
// the shared bit-serial divider (position, then derivative when the target is not reached)
// and of the bit-serial multipliers for the gain products.
// Reset: synchronous, clears the loop state, output valid and configuration registers to reset values.
module pid_position_drive_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [ppd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [ppd_pkg::DATA_W-1:0]          cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [ppd_pkg::DATA_W-1:0]   encoder_count,
  input  logic [ppd_pkg::DT_W-1:0]            elapsed_ms,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [ppd_pkg::DRIVE_W-1:0]  drive,
  output logic                                reached,
  output logic signed [ppd_pkg::DATA_W-1:0]   position
);
  import ppd_pkg::*;

  localparam logic [DATA_W-1:0]   S32_MAX     = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0]   S32_MIN     = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic [DATA_W-1:0]   REACH_LIM_V = DATA_W'(REACH_LIMIT);
  localparam logic [SCALED_W-1:0] SC_HI       = SCALED_W'(DRIVE_LIMIT);
  localparam logic [SCALED_W-1:0] SC_LO       = SCALED_W'(-DRIVE_LIMIT);

  // configuration
  logic [DATA_W-1:0] target_position;
  logic [DATA_W-1:0] start_count;
  logic [DEN_W-1:0]  gear_ratio;
  logic [GAIN_W-1:0] gain_p;
  logic [GAIN_W-1:0] gain_i;
  logic [GAIN_W-1:0] gain_d;

  // loop state
  state_t            state;
  state_t            state_next;
  logic [DATA_W-1:0] previous_error;
  logic [DATA_W-1:0] error_integral;

  // working registers
  logic [DT_W-1:0]    dt_r;
  logic [WIDE_W-1:0]  sdiff;
  logic [DATA_W-1:0]  pos_r;
  logic [DATA_W-1:0]  error_r;
  logic [MUL_A_W-1:0] deriv_r;
  logic [SUM_W-1:0]   sum_r;
  logic [DRIVE_W-1:0] res_drive;
  logic               res_reached;

  logic in_accept;
  logic is_reached;
  logic div_start;
  logic mul_int_start;
  logic mul_pid_start;
  logic out_load;

  // divider
  logic [WIDE_W-1:0] div_num;
  logic [DEN_W-1:0]  div_den;
  logic [DEN_W-1:0]  gear_eff;
  logic              div_done;
  logic [WIDE_W-1:0] div_quot;

  // multipliers
  logic [MUL_A_W-1:0] err_ext;
  logic [MUL_A_W-1:0] int_ext;
  logic [GAIN_W-1:0]  mp_b;
  logic               mp_done;
  logic               mi_done;
  logic               md_done;
  logic [MUL_P_W-1:0] mp_prod;
  logic [MUL_P_W-1:0] mi_prod;
  logic [MUL_P_W-1:0] md_prod;

  // combinational results
  logic [WIDE_W-1:0]  err_wide;
  logic [DATA_W-1:0]  err_sat;
  logic [DATA_W-1:0]  pos_sat;
  logic [MUL_P_W-1:0] int_sum;
  logic [DATA_W-1:0]  int_sat;
  logic [MUL_A_W-1:0] deriv_val;
  logic [SCALED_W-1:0] sum_ext;
  logic [SCALED_W-1:0] scaled;
  logic [DRIVE_W-1:0] drive_val;

  assign cfg_ready = 1'b1;
  assign in_stall  = state != S_IDLE;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_position <= '0;
      start_count     <= '0;
      gear_ratio      <= GEAR_RESET;
      gain_p          <= '0;
      gain_i          <= '0;
      gain_d          <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_TARGET: target_position <= cfg_data;
        REG_START:  start_count     <= cfg_data;
        REG_GEAR:   gear_ratio      <= cfg_data[DEN_W-1:0];
        REG_GAIN_P: gain_p          <= cfg_data[GAIN_W-1:0];
        REG_GAIN_I: gain_i          <= cfg_data[GAIN_W-1:0];
        REG_GAIN_D: gain_d          <= cfg_data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // shared divider: position first, then the error difference over dt
  assign gear_eff = (gear_ratio == '0) ? DEN_W'(1) : gear_ratio;
  assign div_num  = sdiff[WIDE_W-1] ? (-sdiff) : sdiff;
  assign div_den  = (state == S_PREP) ? gear_eff : dt_r;

  ppd_divider #(
    .NUM_W (WIDE_W),
    .DEN_W (DEN_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  // the P unit also forms error * dt for the integral
  assign err_ext = {{(MUL_A_W-DATA_W){error_r[DATA_W-1]}}, error_r};
  assign int_ext = {{(MUL_A_W-DATA_W){error_integral[DATA_W-1]}}, error_integral};
  assign mp_b    = (state == S_PID) ? gain_p : dt_r;

  ppd_serial_mult #(
    .A_W (MUL_A_W),
    .B_W (GAIN_W)
  ) u_mul_p (
    .clk      (clk),
    .rst      (rst),
    .start    (mul_int_start || mul_pid_start),
    .b_signed (mul_pid_start),
    .a        (err_ext),
    .b        (mp_b),
    .done     (mp_done),
    .product  (mp_prod)
  );

  ppd_serial_mult #(
    .A_W (MUL_A_W),
    .B_W (GAIN_W)
  ) u_mul_i (
    .clk      (clk),
    .rst      (rst),
    .start    (mul_pid_start),
    .b_signed (1'b1),
    .a        (int_ext),
    .b        (gain_i),
    .done     (mi_done),
    .product  (mi_prod)
  );

  ppd_serial_mult #(
    .A_W (MUL_A_W),
    .B_W (GAIN_W)
  ) u_mul_d (
    .clk      (clk),
    .rst      (rst),
    .start    (mul_pid_start),
    .b_signed (1'b1),
    .a        (deriv_r),
    .b        (gain_d),
    .done     (md_done),
    .product  (md_prod)
  );

  // position from the magnitude quotient, saturated to 32 bits
  always_comb begin
    if (!sdiff[WIDE_W-1]) begin
      pos_sat = (div_quot[WIDE_W-1] || div_quot[DATA_W-1]) ? S32_MAX : div_quot[DATA_W-1:0];
    end else if (div_quot[WIDE_W-1] ||
                 (div_quot[DATA_W-1] && (div_quot[DATA_W-2:0] != '0))) begin
      pos_sat = S32_MIN;
    end else begin
      pos_sat = -div_quot[DATA_W-1:0];
    end
  end

  assign err_wide = {target_position[DATA_W-1], target_position} - {pos_r[DATA_W-1], pos_r};
  assign err_sat  = (err_wide[WIDE_W-1] != err_wide[DATA_W-1]) ?
                    (err_wide[WIDE_W-1] ? S32_MIN : S32_MAX) : err_wide[DATA_W-1:0];

  assign is_reached = $signed(error_r) <= $signed(REACH_LIM_V);

  assign int_sum = {{(MUL_P_W-DATA_W){error_integral[DATA_W-1]}}, error_integral} + mp_prod;
  always_comb begin
    if ((&int_sum[MUL_P_W-1:DATA_W-1]) || !(|int_sum[MUL_P_W-1:DATA_W-1])) begin
      int_sat = int_sum[DATA_W-1:0];
    end else begin
      int_sat = int_sum[MUL_P_W-1] ? S32_MIN : S32_MAX;
    end
  end

  always_comb begin
    if (dt_r == '0) begin
      deriv_val = '0;
    end else if (sdiff[WIDE_W-1]) begin
      deriv_val = -{1'b0, div_quot};
    end else begin
      deriv_val = {1'b0, div_quot};
    end
  end

  // times five, clamp, negate
  assign sum_ext = {{(SCALED_W-SUM_W){sum_r[SUM_W-1]}}, sum_r};
  assign scaled  = sum_ext + (sum_ext << 2);
  always_comb begin
    priority if ($signed(scaled) > $signed(SC_HI)) begin
      drive_val = DRIVE_LO;
    end else if ($signed(scaled) < $signed(SC_LO)) begin
      drive_val = DRIVE_HI;
    end else begin
      drive_val = -scaled[DRIVE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    div_start     = 1'b0;
    mul_int_start = 1'b0;
    mul_pid_start = 1'b0;
    out_load      = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_accept) state_next = S_PREP;
      end
      S_PREP: begin
        div_start  = 1'b1;
        state_next = S_DIV_POS;
      end
      S_DIV_POS: begin
        if (div_done) state_next = S_ERR;
      end
      S_ERR: begin
        state_next = S_DIFF;
      end
      S_DIFF: begin
        if (is_reached) begin
          state_next = S_DONE;
        end else begin
          mul_int_start = 1'b1;
          state_next    = S_DDIV;
        end
      end
      S_DDIV: begin
        div_start  = 1'b1;
        state_next = S_WAIT_DER;
      end
      S_WAIT_DER: begin
        if (div_done && mp_done) state_next = S_PID;
      end
      S_PID: begin
        mul_pid_start = 1'b1;
        state_next    = S_WAIT_PID;
      end
      S_WAIT_PID: begin
        if (mp_done && mi_done && md_done) state_next = S_SCALE;
      end
      S_SCALE: begin
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!out_valid || !out_stall) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_error <= '0;
      error_integral <= '0;
    end else if (state == S_DIFF && is_reached) begin
      previous_error <= '0;
      error_integral <= '0;
    end else if (state == S_WAIT_DER && div_done && mp_done) begin
      error_integral <= int_sat;
    end else if (state == S_SCALE) begin
      previous_error <= error_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      dt_r  <= elapsed_ms;
      sdiff <= {encoder_count[DATA_W-1], encoder_count} - {start_count[DATA_W-1], start_count};
    end
    if (state == S_DIV_POS && div_done) pos_r <= pos_sat;
    if (state == S_ERR) error_r <= err_sat;
    if (state == S_DIFF) begin
      sdiff       <= {error_r[DATA_W-1], error_r} - {previous_error[DATA_W-1], previous_error};
      res_drive   <= '0;
      res_reached <= is_reached;
    end
    if (state == S_WAIT_DER && div_done) deriv_r <= deriv_val;
    if (state == S_WAIT_PID) begin
      sum_r <= {{(SUM_W-MUL_P_W){mp_prod[MUL_P_W-1]}}, mp_prod}
             + {{(SUM_W-MUL_P_W){mi_prod[MUL_P_W-1]}}, mi_prod}
             + {{(SUM_W-MUL_P_W){md_prod[MUL_P_W-1]}}, md_prod};
    end
    if (state == S_SCALE) res_drive <= drive_val;
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      drive    <= res_drive;
      reached  <= res_reached;
      position <= pos_r;
    end
  end

endmodule

[src/ppd_checker.sv]
// Port-level checks on the PID position drive, bound to the top level.
module ppd_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               in_valid,
  input logic                               in_stall,
  input logic                               out_valid,
  input logic                               out_stall,
  input logic signed [ppd_pkg::DRIVE_W-1:0] drive,
  input logic                               reached
);
  import ppd_pkg::*;

  // one word in flight: taking a word makes the block busy
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not stalled after a word was taken");

  a_reached_zero_drive: assert property (@(posedge clk) disable iff (rst)
    (out_valid && reached) |-> (drive == '0))
    else $error("drive not zero with reached set");

  a_drive_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ($signed(drive) <= $signed(DRIVE_HI) && $signed(drive) >= $signed(DRIVE_LO)))
    else $error("drive outside limits");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(drive) && $stable(reached)))
    else $error("stalled output word changed");

endmodule

bind pid_position_drive_top ppd_checker u_ppd_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .drive     (drive),
  .reached   (reached)
);

[bench/ppd_tick_checker.sv]
// Tick checker for the PID position drive: mirrors the registers, predicts each result word, compares.
module ppd_tick_checker
  import ppd_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  input  logic                        cfg_ready,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [DATA_W-1:0]           cfg_data,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic signed [DATA_W-1:0]    encoder_count,
  input  logic [DT_W-1:0]             elapsed_ms,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic signed [DRIVE_W-1:0]   drive,
  input  logic                        reached,
  input  logic signed [DATA_W-1:0]    position,
  output int                          fail_count,
  output int                          pending
);

  localparam int     DRIVE_SCALE = 5;
  localparam longint WORD_MAX    = longint'(2147483647);
  localparam longint WORD_MIN    = -longint'(2147483647) - 1;

  typedef struct packed {
    logic signed [DRIVE_W-1:0] drive;
    logic                      reached;
    logic signed [DATA_W-1:0]  position;
  } tick_word_t;

  logic signed [DATA_W-1:0] target_pos;
  logic signed [DATA_W-1:0] start_cnt;
  logic [DEN_W-1:0]         gear;
  logic signed [GAIN_W-1:0] kp;
  logic signed [GAIN_W-1:0] ki;
  logic signed [GAIN_W-1:0] kd;
  logic signed [DATA_W-1:0] err_prev;
  logic signed [DATA_W-1:0] err_sum;

  tick_word_t expected_ticks[$];
  int         mismatches;

  function automatic logic signed [DATA_W-1:0] clip_word(input longint v);
    if (v > WORD_MAX) return DATA_W'(WORD_MAX);
    if (v < WORD_MIN) return DATA_W'(WORD_MIN);
    return DATA_W'(v);
  endfunction

  // Advances the loop state by one tick and returns the word it should produce.
  function automatic tick_word_t predict_tick(input logic signed [DATA_W-1:0] count,
                                              input logic [DT_W-1:0] dt);
    longint                   div;
    longint                   deriv;
    longint                   pid;
    logic signed [DATA_W-1:0] pos;
    logic signed [DATA_W-1:0] err;
    tick_word_t               w;
    div = (gear == '0) ? 1 : longint'(gear);
    pos = clip_word((longint'(count) - longint'(start_cnt)) / div);
    err = clip_word(longint'(target_pos) - longint'(pos));
    w.position = pos;
    if (err <= REACH_LIMIT) begin
      w.drive   = '0;
      w.reached = 1'b1;
      err_prev  = '0;
      err_sum   = '0;
    end else begin
      err_sum = clip_word(longint'(err_sum) + longint'(err) * longint'(dt));
      deriv   = (dt == '0) ? 0 : (longint'(err) - longint'(err_prev)) / longint'(dt);
      pid = DRIVE_SCALE * (longint'(kp) * longint'(err) + longint'(ki) * longint'(err_sum)
                           + longint'(kd) * deriv);
      if (pid > DRIVE_LIMIT) pid = DRIVE_LIMIT;
      else if (pid < -DRIVE_LIMIT) pid = -DRIVE_LIMIT;
      w.drive   = DRIVE_W'(-pid);
      w.reached = 1'b0;
      err_prev  = err;
    end
    return w;
  endfunction

  always @(posedge clk) begin
    tick_word_t want;
    if (rst) begin
      target_pos = '0;
      start_cnt  = '0;
      gear       = GEAR_RESET;
      kp         = '0;
      ki         = '0;
      kd         = '0;
      err_prev   = '0;
      err_sum    = '0;
      expected_ticks.delete();
    end else begin
      // results first: a word taken this edge cannot belong to a tick taken on the same edge
      if (out_valid && !out_stall) begin
        if (expected_ticks.size() == 0) begin
          $display("%0t: result word with none expected: drive %0d reached %0d position %0d",
                   $time, drive, reached, position);
          mismatches++;
        end else begin
          want = expected_ticks.pop_front();
          if (drive !== want.drive) begin
            $display("%0t: drive expected %0d actual %0d", $time, want.drive, drive);
            mismatches++;
          end
          if (reached !== want.reached) begin
            $display("%0t: reached expected %0d actual %0d", $time, want.reached, reached);
            mismatches++;
          end
          if (position !== want.position) begin
            $display("%0t: position expected %0d actual %0d", $time, want.position, position);
            mismatches++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_TARGET: target_pos = cfg_data;
          REG_START:  start_cnt  = cfg_data;
          REG_GEAR:   gear       = cfg_data[DEN_W-1:0];
          REG_GAIN_P: kp         = cfg_data[GAIN_W-1:0];
          REG_GAIN_I: ki         = cfg_data[GAIN_W-1:0];
          REG_GAIN_D: kd         = cfg_data[GAIN_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) expected_ticks.push_back(predict_tick(encoder_count, elapsed_ms));
    end
    fail_count <= mismatches;
    pending    <= expected_ticks.size();
  end

endmodule

[bench/pid_position_drive_top_tb.sv]
// Stimulus, idling, watchdog and verdict for the PID position drive.
module pid_position_drive_top_tb;
  import ppd_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_CYCLES    = 400;
  localparam int IDLE_PCT       = 16;
  localparam int RANDOM_PHASES  = 16;
  localparam int PHASE_TICKS    = 105;
  localparam int TAIL_CYCLES    = 100;
  localparam int STYLE_NORMAL   = 0;
  localparam int STYLE_MAX      = 1;
  localparam int STYLE_MIN      = 2;

  // indexes past the last register, writes there must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = CFG_IDX_W'(6);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = CFG_IDX_W'(7);

  logic                       clk = 1'b0;
  logic                       rst;
  logic                       cfg_valid;
  logic                       cfg_ready;
  logic [CFG_IDX_W-1:0]       cfg_index;
  logic [DATA_W-1:0]          cfg_data;
  logic                       in_valid;
  logic                       in_stall;
  logic signed [DATA_W-1:0]   encoder_count;
  logic [DT_W-1:0]            elapsed_ms;
  logic                       out_valid;
  logic                       out_stall;
  logic signed [DRIVE_W-1:0]  drive;
  logic                       reached;
  logic signed [DATA_W-1:0]   position;

  int   fail_count;
  int   pending;
  int   idle_cycles = 0;
  logic quiet;
  logic hold_req;

  // mirror of the settings in force, used to aim encoder counts near the target
  int   cur_target;
  int   cur_start;
  int   cur_gear;

  always #5 clk = ~clk;

  pid_position_drive_top dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .encoder_count (encoder_count),
    .elapsed_ms    (elapsed_ms),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .drive         (drive),
    .reached       (reached),
    .position      (position)
  );

  ppd_tick_checker u_check (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .encoder_count (encoder_count),
    .elapsed_ms    (elapsed_ms),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .drive         (drive),
    .reached       (reached),
    .position      (position),
    .fail_count    (fail_count),
    .pending       (pending)
  );

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // result side: random stalls, one long hold-off when asked
  initial begin : receiver
    bit held;
    held = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !held) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
      end else begin
        if (!hold_req) held = 1'b0;
        out_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
      end
    end
  end

  // leaves cfg_valid high; the caller lowers it after the last write of a group
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic send_tick(input logic [DATA_W-1:0] count, input logic [DT_W-1:0] dt);
    while (!quiet && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    encoder_count <= count;
    elapsed_ms    <= dt;
    do @(posedge clk); while (in_stall);
  endtask

  // pending is registered in the checker, so the first edge is always waited
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  function automatic int pick_gain();
    if ($urandom_range(7) == 0) return int'($urandom_range(65535));
    if ($urandom_range(2) == 0) return 0;
    return int'($urandom_range(40)) - 20;
  endfunction

  task automatic random_config(input int style);
    int kp;
    int ki;
    int kd;
    case (style)
      STYLE_MAX: begin
        cur_target = 32'h7fffffff;
        cur_start  = 32'h7fffffff;
        cur_gear   = 65535;
        kp = 32767; ki = 32767; kd = 32767;
      end
      STYLE_MIN: begin
        cur_target = 32'h80000000;
        cur_start  = 32'h80000000;
        cur_gear   = 1;
        kp = -32768; ki = -32768; kd = -32768;
      end
      default: begin
        cur_target = ($urandom_range(3) == 0) ? int'($urandom)
                                             : int'($urandom_range(8000)) - 4000;
        cur_start  = ($urandom_range(3) == 0) ? int'($urandom)
                                             : int'($urandom_range(200000)) - 100000;
        case ($urandom_range(9))
          0:       cur_gear = 0;
          1:       cur_gear = 65535;
          2:       cur_gear = int'($urandom_range(65535));
          default: cur_gear = int'($urandom_range(100, 1));
        endcase
        kp = pick_gain();
        ki = pick_gain();
        kd = pick_gain();
      end
    endcase
    cfg_write(REG_TARGET, cur_target);
    cfg_write(REG_START, cur_start);
    cfg_write(REG_GEAR, cur_gear);
    cfg_write(REG_GAIN_P, kp);
    cfg_write(REG_GAIN_I, ki);
    cfg_write(REG_GAIN_D, kd);
    if ($urandom_range(3) == 0) cfg_write($urandom_range(1) ? REG_SPARE_HI : REG_SPARE_LO, $urandom);
    cfg_valid <= 1'b0;
  endtask

  // mostly an approach towards the target with a shrinking error, some overshoot and noise
  task automatic run_phase(input int n, input bit mid_pause);
    int     gap;
    int     g;
    int     roll;
    longint aim;
    logic [DT_W-1:0] dt;
    gap = int'($urandom_range(3000, 50));
    g   = (cur_gear == 0) ? 1 : cur_gear;
    for (int i = 0; i < n; i++) begin
      if (mid_pause && i == n / 2) wait_drained();
      roll = int'($urandom_range(99));
      if (roll < 8) begin
        send_tick($urandom, DT_W'($urandom_range(65535)));
      end else begin
        gap = gap - int'($urandom_range(gap / 4 + 2));
        if (gap < -3) gap = int'($urandom_range(3000, 50));
        dt  = (roll < 13) ? '0 : DT_W'($urandom_range(20, 5));
        aim = longint'(cur_start) + (longint'(cur_target) - longint'(gap)) * longint'(g)
              + longint'($urandom_range(g - 1));
        send_tick(DATA_W'(aim), dt);
      end
    end
    wait_drained();
  endtask

  initial begin
    rst           <= 1'b1;
    cfg_valid     <= 1'b0;
    cfg_index     <= REG_TARGET;
    cfg_data      <= '0;
    in_valid      <= 1'b0;
    encoder_count <= '0;
    elapsed_ms    <= '0;
    quiet         <= 1'b0;
    hold_req      <= 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // settings from reset: gear 34, no gains
    send_tick('0, '0);
    send_tick(32'h7fffffff, 16'hffff);
    send_tick(32'h80000000, 16'h0001);
    wait_drained();

    // small loop near the target: the threshold edge and a zero elapsed time
    cfg_write(REG_TARGET, 1000);
    cfg_write(REG_START, 0);
    cfg_write(REG_GEAR, 1);
    cfg_write(REG_GAIN_P, 3);
    cfg_write(REG_GAIN_I, 1);
    cfg_write(REG_GAIN_D, 2);
    cfg_valid <= 1'b0;
    send_tick(998, DT_W'(10));
    send_tick(998, '0);
    send_tick(999, DT_W'(10));
    send_tick(0, 16'hffff);
    send_tick(-5000, 16'hffff);
    wait_drained();

    // zero gear, position and error both saturating, integral pinned at the top
    cfg_write(REG_GEAR, 0);
    cfg_write(REG_START, 32'h7fffffff);
    cfg_write(REG_TARGET, 32'h7fffffff);
    cfg_write(REG_GAIN_P, 32'h7fff);
    cfg_write(REG_GAIN_I, 32'h8000);
    cfg_write(REG_GAIN_D, 32'h7fff);
    cfg_write(REG_SPARE_LO, $urandom);
    cfg_write(REG_SPARE_HI, $urandom);
    cfg_valid <= 1'b0;
    send_tick(32'h80000000, 16'hffff);
    send_tick(32'h80000000, 16'hffff);
    send_tick(32'h7fffffff, '0);
    wait_drained();

    // position saturating high, error saturating low
    cfg_write(REG_START, 32'h80000000);
    cfg_write(REG_TARGET, 32'h80000000);
    cfg_write(REG_GEAR, 1);
    cfg_write(REG_GAIN_P, 32'h8000);
    cfg_write(REG_GAIN_I, 32'h8000);
    cfg_write(REG_GAIN_D, 32'h8000);
    cfg_valid <= 1'b0;
    send_tick(32'h7fffffff, DT_W'(1));
    send_tick(32'h80000000, DT_W'(1));
    wait_drained();

    // integral overflow at the largest gear
    cfg_write(REG_TARGET, 32'h7fffffff);
    cfg_write(REG_START, 0);
    cfg_write(REG_GEAR, 32'hffff);
    cfg_write(REG_GAIN_P, 0);
    cfg_write(REG_GAIN_I, 1);
    cfg_write(REG_GAIN_D, 32'hffff);
    cfg_valid <= 1'b0;
    repeat (3) send_tick('0, 16'hffff);
    wait_drained();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      random_config((p == 1) ? STYLE_MAX : (p == 2) ? STYLE_MIN : STYLE_NORMAL);
      if (p == 4) quiet <= 1'b1;
      if (p == 6) hold_req <= 1'b1;
      run_phase(PHASE_TICKS, (p % 4) == 3);
      quiet    <= 1'b0;
      hold_req <= 1'b0;
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
